// ===== rtl/gcn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and offset tables for the grid cell neighbor generator.
// Used by gcn_select, gcn_walk and grid_cell_neighbor_generator.
package gcn_pkg;

  localparam int COORD_BITS = 16;
  localparam int NB_BITS    = COORD_BITS + 1;
  localparam int LAYER_BITS = 15;
  localparam int CMP_BITS   = ((NB_BITS > LAYER_BITS) ? NB_BITS : LAYER_BITS) + 1;
  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
  localparam int NUM_TBLS   = 5;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_KIND     = 3'd0,
    REG_STAGGER_AXIS  = 3'd1,
    REG_STAGGER_INDEX = 3'd2,
    REG_LAYER_WIDTH   = 3'd3,
    REG_LAYER_HEIGHT  = 3'd4
  } cfg_reg_t;

  localparam logic GRID_ORTHO = 1'b0;
  localparam logic GRID_HEX   = 1'b1;
  localparam logic AXIS_X     = 1'b0;

  // Which offset table a query walks.
  typedef enum logic [2:0] {
    TBL_ORTHO = 3'd0,
    TBL_HX0   = 3'd1,
    TBL_HX1   = 3'd2,
    TBL_HY0   = 3'd3,
    TBL_HY1   = 3'd4
  } tbl_t;

  localparam logic [NUM_SLOTS-1:0] MASK_ORTHO_EDGE = 8'h0F;
  localparam logic [NUM_SLOTS-1:0] MASK_ORTHO_ALL  = 8'hFF;
  localparam logic [NUM_SLOTS-1:0] MASK_HEX        = 8'h3F;

  localparam logic signed [1:0] M1 = 2'sb11;
  localparam logic signed [1:0] Z0 = 2'sb00;
  localparam logic signed [1:0] P1 = 2'sb01;

  localparam logic signed [1:0] OFS_DX [NUM_TBLS][NUM_SLOTS] = '{
    '{M1, P1, Z0, Z0, M1, P1, M1, P1},
    '{P1, P1, Z0, M1, M1, Z0, Z0, Z0},
    '{P1, P1, Z0, M1, M1, Z0, Z0, Z0},
    '{P1, Z0, M1, M1, M1, Z0, Z0, Z0},
    '{P1, P1, Z0, M1, Z0, P1, Z0, Z0}
  };

  localparam logic signed [1:0] OFS_DY [NUM_TBLS][NUM_SLOTS] = '{
    '{Z0, Z0, M1, P1, M1, M1, P1, P1},
    '{Z0, M1, M1, M1, Z0, P1, Z0, Z0},
    '{P1, Z0, M1, Z0, P1, P1, Z0, Z0},
    '{Z0, M1, M1, Z0, P1, P1, Z0, Z0},
    '{Z0, M1, M1, Z0, P1, P1, Z0, Z0}
  };

  typedef struct packed {
    logic                  grid_kind;
    logic                  stagger_axis;
    logic                  stagger_index;
    logic [LAYER_BITS-1:0] layer_width;
    logic [LAYER_BITS-1:0] layer_height;
  } cfg_t;

  // One query ready for the walker: the cell, its table and surviving slots.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    tbl_t                         tbl;
    logic [NUM_SLOTS-1:0]         mask;
  } query_t;

endpackage

// ===== rtl/grid_cell_neighbor_generator.sv =====
`timescale 1ns / 1ps
// Path: an accepted query goes through the input register in gcn_select, then the walker's
// query register and result register in gcn_walk. One result word per cycle while out_ready
// allows; a query yields one word per surviving neighbor (up to 8), or a single empty word,
// and the next query waits in the input register until the walker emits the query's last word.
// Reset (rst, synchronous): configuration registers clear to 0, pipeline empties.
module grid_cell_neighbor_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gcn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [gcn_pkg::LAYER_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gcn_pkg::COORD_BITS-1:0] cell_x,
  input  logic signed [gcn_pkg::COORD_BITS-1:0] cell_y,
  input  logic                                  want_diagonal,
  input  logic                                  only_valid,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gcn_pkg::NB_BITS-1:0]    neighbor_x,
  output logic signed [gcn_pkg::NB_BITS-1:0]    neighbor_y,
  output logic                                  found,
  output logic                                  last
);
  import gcn_pkg::*;

  cfg_t   cfg;
  query_t q;
  logic   q_valid;
  logic   q_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_KIND:     cfg.grid_kind     <= cfg_data[0];
        REG_STAGGER_AXIS:  cfg.stagger_axis  <= cfg_data[0];
        REG_STAGGER_INDEX: cfg.stagger_index <= cfg_data[0];
        REG_LAYER_WIDTH:   cfg.layer_width   <= cfg_data;
        REG_LAYER_HEIGHT:  cfg.layer_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  gcn_select u_select (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .want_diagonal (want_diagonal),
    .only_valid    (only_valid),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q             (q),
    .q_take        (q_take)
  );

  gcn_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q          (q),
    .q_take     (q_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .neighbor_x (neighbor_x),
    .neighbor_y (neighbor_y),
    .found      (found),
    .last       (last)
  );

`ifndef NO_ASSERTIONS
  // An empty query gives exactly one word, and that word closes the query.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> last)
    else $error("empty result word without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (neighbor_x == '0 && neighbor_y == '0))
    else $error("empty result word carries a coordinate");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid right after reset");

  // A query is handed to the walker only when the walker is free or finishing.
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_take) |=> q_valid)
    else $error("pending query lost before handoff");
`endif

endmodule

// ===== rtl/gcn_select.sv =====
`timescale 1ns / 1ps
// Input register and per-slot neighbor evaluation: table choice and layer filter.
// Depends on gcn_pkg.
module gcn_select (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [gcn_pkg::COORD_BITS-1:0] cell_x,
  input  logic signed [gcn_pkg::COORD_BITS-1:0] cell_y,
  input  logic                                 want_diagonal,
  input  logic                                 only_valid,
  input  gcn_pkg::cfg_t                        cfg,
  output logic                                 q_valid,
  output gcn_pkg::query_t                      q,
  input  logic                                 q_take
);
  import gcn_pkg::*;

  logic                         r_valid;
  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] ry;
  logic                         rdiag;
  logic                         rfilt;

  tbl_t                         tbl;
  logic [NUM_SLOTS-1:0]         cnt_mask;
  logic [NUM_SLOTS-1:0]         keep;
  logic signed [CMP_BITS-1:0]   nx [NUM_SLOTS];
  logic signed [CMP_BITS-1:0]   ny [NUM_SLOTS];
  logic signed [CMP_BITS-1:0]   lim_w;
  logic signed [CMP_BITS-1:0]   lim_h;
  logic                         par;

  assign in_ready = !r_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_ready) begin
      r_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      rx    <= cell_x;
      ry    <= cell_y;
      rdiag <= want_diagonal;
      rfilt <= only_valid;
    end
  end

  always_comb begin
    par = (cfg.stagger_axis == AXIS_X) ? rx[0] : ry[0];
    if (cfg.grid_kind == GRID_ORTHO) begin
      tbl      = TBL_ORTHO;
      cnt_mask = rdiag ? MASK_ORTHO_ALL : MASK_ORTHO_EDGE;
    end else begin
      cnt_mask = MASK_HEX;
      if (cfg.stagger_axis == AXIS_X) begin
        tbl = (par == cfg.stagger_index) ? TBL_HX0 : TBL_HX1;
      end else begin
        tbl = (par == cfg.stagger_index) ? TBL_HY0 : TBL_HY1;
      end
    end
  end

  assign lim_w = $signed(CMP_BITS'(cfg.layer_width));
  assign lim_h = $signed(CMP_BITS'(cfg.layer_height));

  // Each slot is checked in parallel against the half-open layer rectangle.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      nx[i]   = CMP_BITS'(rx) + CMP_BITS'(OFS_DX[tbl][i]);
      ny[i]   = CMP_BITS'(ry) + CMP_BITS'(OFS_DY[tbl][i]);
      keep[i] = cnt_mask[i] &&
                (!rfilt || (nx[i] >= 0 && nx[i] < lim_w && ny[i] >= 0 && ny[i] < lim_h));
    end
  end

  assign q_valid = r_valid;
  assign q.cx    = rx;
  assign q.cy    = ry;
  assign q.tbl   = tbl;
  assign q.mask  = keep;

endmodule

// ===== rtl/gcn_walk.sv =====
`timescale 1ns / 1ps
// Walks the surviving slots of one query and fills the result register.
// Depends on gcn_pkg.
module gcn_walk (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  gcn_pkg::query_t                       q,
  output logic                                  q_take,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gcn_pkg::NB_BITS-1:0]    neighbor_x,
  output logic signed [gcn_pkg::NB_BITS-1:0]    neighbor_y,
  output logic                                  found,
  output logic                                  last
);
  import gcn_pkg::*;

  logic                        busy;
  query_t                      cur;
  logic [SLOT_BITS-1:0]        idx;
  logic [NUM_SLOTS-1:0]        onehot;
  logic [NUM_SLOTS-1:0]        rest;
  logic                        has;
  logic                        last_pick;
  logic                        out_load;
  logic signed [NB_BITS-1:0]   nx;
  logic signed [NB_BITS-1:0]   ny;

  always_comb begin
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        idx = SLOT_BITS'(i);
      end
    end
  end

  assign onehot    = cur.mask & (~cur.mask + 1'b1);
  assign rest      = cur.mask & ~onehot;
  assign has       = |cur.mask;
  assign last_pick = (rest == '0);

  assign nx = NB_BITS'(cur.cx) + NB_BITS'(OFS_DX[cur.tbl][idx]);
  assign ny = NB_BITS'(cur.cy) + NB_BITS'(OFS_DY[cur.tbl][idx]);

  assign out_load = busy && (!out_valid || out_ready);
  // The next query moves in on the cycle its predecessor emits its final word.
  assign q_take   = !busy || (out_load && last_pick);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_take) begin
        busy <= q_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (q_take && q_valid) begin
      cur <= q;
    end else if (out_load) begin
      cur.mask <= rest;
    end
    if (out_load) begin
      found      <= has;
      last       <= last_pick;
      neighbor_x <= has ? nx : '0;
      neighbor_y <= has ? ny : '0;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_cell_neighbor_generator: directed and random
// queries, a scoreboard of expected neighbor words. Depends on gcn_pkg.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CB = gcn_pkg::COORD_BITS;
  localparam int NB = gcn_pkg::NB_BITS;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 diag;
    logic                 filt;
  } cell_query_t;

  typedef struct packed {
    logic signed [NB-1:0] nx;
    logic signed [NB-1:0] ny;
    logic                 found;
    logic                 last;
  } nbr_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gcn_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [gcn_pkg::LAYER_BITS-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [CB-1:0]          cell_x = '0;
  logic signed [CB-1:0]          cell_y = '0;
  logic                          want_diagonal = 1'b0;
  logic                          only_valid = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [NB-1:0]          neighbor_x;
  logic signed [NB-1:0]          neighbor_y;
  logic                          found;
  logic                          last;

  grid_cell_neighbor_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .want_diagonal (want_diagonal),
    .only_valid    (only_valid),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .neighbor_x    (neighbor_x),
    .neighbor_y    (neighbor_y),
    .found         (found),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offset tables, indexed [stagger axis][table][slot] for the hex grids.
  int ortho_dx [8] = '{-1, 1, 0, 0, -1, 1, -1, 1};
  int ortho_dy [8] = '{0, 0, -1, 1, -1, -1, 1, 1};
  int hex_dx [2][2][6] = '{'{'{1, 1, 0, -1, -1, 0}, '{1, 1, 0, -1, -1, 0}},
                           '{'{1, 0, -1, -1, -1, 0}, '{1, 1, 0, -1, 0, 1}}};
  int hex_dy [2][2][6] = '{'{'{0, -1, -1, -1, 0, 1}, '{1, 0, -1, 0, 1, 1}},
                           '{'{0, -1, -1, 0, 1, 1}, '{0, -1, -1, 0, 1, 1}}};

  // Layout as the block should currently hold it.
  bit grid_hex;
  bit stag_axis;
  bit stag_index;
  int layer_w;
  int layer_h;

  cell_query_t query_q[$];
  nbr_word_t   nbr_expect_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          long_hold_req = 1'b0;

  int burst_left;
  int gap_left;
  int rx_tick;
  int hold_left;

  function automatic void predict_neighbors(int cx, int cy, bit diag, bit filt);
    nbr_word_t run[$];
    nbr_word_t w;
    int cnt;
    int t;
    int k;
    int nx;
    int ny;
    bit par;
    t = 0;
    if (!grid_hex) begin
      cnt = diag ? 8 : 4;
    end else begin
      par = stag_axis ? cy[0] : cx[0];
      t = (par == stag_index) ? 0 : 1;
      cnt = 6;
    end
    for (k = 0; k < cnt; k++) begin
      if (!grid_hex) begin
        nx = cx + ortho_dx[k];
        ny = cy + ortho_dy[k];
      end else begin
        nx = cx + hex_dx[stag_axis][t][k];
        ny = cy + hex_dy[stag_axis][t][k];
      end
      if (filt && (nx < 0 || nx >= layer_w || ny < 0 || ny >= layer_h))
        continue;
      w.nx = nx[NB-1:0];
      w.ny = ny[NB-1:0];
      w.found = 1'b1;
      w.last = 1'b0;
      run.insert(run.size(), w);
    end
    // An empty run still yields one word that says nothing was found.
    if (run.size() == 0) begin
      w = '0;
      run.insert(run.size(), w);
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) nbr_expect_q.insert(nbr_expect_q.size(), run[i]);
  endfunction

  function automatic void check_field(string name, logic signed [NB-1:0] expv,
                                      logic signed [NB-1:0] act);
    if (act !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, act);
      err_count++;
    end
  endfunction

  function automatic logic [CB-1:0] pick_coord(int span);
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: return CB'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return CB'($urandom_range(0, span + 4) - 2);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 32767);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic void add_query(int x, int y, bit d, bit f);
    cell_query_t q;
    q.x = x[CB-1:0];
    q.y = y[CB-1:0];
    q.diag = d;
    q.filt = f;
    query_q.insert(query_q.size(), q);
  endfunction

  function automatic void add_random_queries(int n);
    cell_query_t q;
    for (int i = 0; i < n; i++) begin
      q.x = pick_coord(layer_w);
      q.y = pick_coord(layer_h);
      q.diag = 1'($urandom_range(0, 1));
      q.filt = ($urandom_range(0, 3) != 0);
      query_q.insert(query_q.size(), q);
    end
  endfunction

  task automatic write_reg(gcn_pkg::cfg_reg_t idx, int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[gcn_pkg::LAYER_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gcn_pkg::REG_GRID_KIND:     grid_hex = data[0];
      gcn_pkg::REG_STAGGER_AXIS:  stag_axis = data[0];
      gcn_pkg::REG_STAGGER_INDEX: stag_index = data[0];
      gcn_pkg::REG_LAYER_WIDTH:   layer_w = data & 32'h7FFF;
      gcn_pkg::REG_LAYER_HEIGHT:  layer_h = data & 32'h7FFF;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_layout(bit kind, bit axis, bit sidx, int w, int h);
    write_reg(gcn_pkg::REG_GRID_KIND, kind);
    write_reg(gcn_pkg::REG_STAGGER_AXIS, axis);
    write_reg(gcn_pkg::REG_STAGGER_INDEX, sidx);
    write_reg(gcn_pkg::REG_LAYER_WIDTH, w);
    write_reg(gcn_pkg::REG_LAYER_HEIGHT, h);
  endtask

  // Every query yields at least one word, so an empty scoreboard means idle;
  // the short pause covers the pipeline latency.
  task automatic wait_idle();
    while (query_q.size() != 0 || in_valid || nbr_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_queries
    bit offer;
    cell_query_t q;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        predict_neighbors(int'(cell_x), int'(cell_y), want_diagonal, only_valid);
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (query_q.size() != 0) begin
          q = query_q.pop_front();
          cell_x        <= q.x;
          cell_y        <= q.y;
          want_diagonal <= q.diag;
          only_valid    <= q.filt;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : drive_ready
    bit rdy;
    if (rst) begin
      out_ready <= 1'b0;
      rx_tick = 0;
      hold_left = 0;
    end else begin
      rx_tick++;
      if (long_hold_req && hold_left == 0) begin
        hold_left = 400;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((rx_tick / 128) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (rx_tick % 5) != 0;
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_words
    nbr_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (nbr_expect_q.size() == 0) begin
        $error("unexpected word: x=%0d y=%0d found=%0b last=%0b",
               neighbor_x, neighbor_y, found, last);
        err_count++;
      end else begin
        exp_w = nbr_expect_q.pop_front();
        check_field("neighbor_x", exp_w.nx, neighbor_x);
        check_field("neighbor_y", exp_w.ny, neighbor_y);
        check_field("found", NB'(exp_w.found), NB'(found));
        check_field("last", NB'(exp_w.last), NB'(last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: orthogonal grid with an empty layer.
    add_query(0, 0, 0, 0);
    add_query(0, 0, 1, 0);
    add_query(-32768, -32768, 1, 0);
    add_query(32767, 32767, 1, 0);
    add_query(5, 5, 1, 1);
    wait_idle();

    set_layout(gcn_pkg::GRID_ORTHO, 1'b0, 1'b0, 32767, 32767);
    add_query(0, 0, 1, 1);
    add_query(32767, 32767, 1, 1);
    add_query(-1, -1, 1, 1);
    add_query(100, -1, 0, 1);
    wait_idle();

    set_layout(gcn_pkg::GRID_HEX, gcn_pkg::AXIS_X, 1'b0, 4, 4);
    add_query(2, 2, 0, 0);
    add_query(3, 2, 1, 0);
    add_query(-1, 1, 0, 0);
    add_query(0, 0, 0, 1);
    add_query(3, 3, 1, 1);
    wait_idle();

    set_layout(gcn_pkg::GRID_HEX, gcn_pkg::AXIS_X, 1'b1, 4, 4);
    add_query(2, 2, 0, 0);
    add_query(3, 1, 0, 1);
    wait_idle();

    set_layout(gcn_pkg::GRID_HEX, 1'b1, 1'b0, 6, 3);
    add_query(2, 2, 0, 0);
    add_query(2, 1, 0, 1);
    add_query(-32768, -32767, 0, 0);
    wait_idle();

    set_layout(gcn_pkg::GRID_HEX, 1'b1, 1'b1, 6, 3);
    add_query(2, 2, 0, 0);
    add_query(1, 1, 0, 1);
    add_query(32767, 32767, 0, 1);
    wait_idle();

    // A single-cell layer has no neighbors at all.
    set_layout(gcn_pkg::GRID_ORTHO, 1'b0, 1'b0, 1, 1);
    add_query(0, 0, 1, 1);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      set_layout(1'(ph % 2), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 pick_size(), pick_size());
      if (ph == 2) begin
        // Keep queries coming while the output is held off, to back up the block.
        add_random_queries(40);
        @(negedge clk);
        long_hold_req = 1'b1;
      end else if (ph == 5) begin
        add_random_queries(20);
        wait_idle();
        add_random_queries(20);
      end else begin
        add_random_queries(40);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gcn_pkg.sv
rtl/gcn_select.sv
rtl/gcn_walk.sv
rtl/grid_cell_neighbor_generator.sv
tb/testbench.sv
